[sv/tsr_pkg.sv]
package tsr_pkg;

  localparam int unsigned FragmentCapacity = 2048;
  localparam int unsigned MaxSegmentLength = 250;
  localparam int unsigned MinSegment       = 2;
  localparam int unsigned FinBit           = 7;
  localparam int unsigned FirBit           = 6;
  localparam int unsigned SeqWidth         = 6;
  localparam int unsigned FragWidth        = 12;
  localparam int unsigned OffsetWidth      = 11;
  localparam int unsigned LimitWidth       = 13;
  localparam logic [11:0] MaxFragmentReset = 12'd2048;

  typedef enum logic [2:0] {
    StatusPayload    = 3'd0,
    StatusHeaderOk   = 3'd1,
    StatusNoPayload  = 3'd2,
    StatusTooLong    = 3'd3,
    StatusNoFirst    = 3'd4,
    StatusBadSeq     = 3'd5,
    StatusOverflow   = 3'd6,
    StatusDroppedByte = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_segment;
    logic [7:0] segment_length;
  } in_item_t;

  typedef struct packed {
    logic                   payload_valid;
    logic [7:0]             payload_byte;
    logic [OffsetWidth-1:0] payload_offset;
    status_e                segment_status;
    logic                   fragment_abort;
    logic                   fragment_done;
    logic [FragWidth-1:0]   fragment_length;
  } out_item_t;

endpackage

[sv/transport_segment_reassembler.sv]
// Byte-serial transport segment reassembler. Each input transfer carries one segment byte; the
// header byte, marked by first_of_segment, is judged at once and decides whether the following
// payload bytes pass through with their fragment offset. Every input transfer yields exactly one
// output transfer via the input register and then the result register, and a new byte is taken
// in every cycle unless the output stalls: the two registers are separated by a single pass of
// counter updates and compares. The user must write the maximum fragment size through cfg_we_i
// and cfg_data_i only while no transfer is in flight; the block itself does not enforce this.
module transport_segment_reassembler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tsr_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsr_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_data_i
);

  logic               in_valid_q;
  tsr_pkg::in_item_t  in_item_q;
  logic               out_valid_q;
  tsr_pkg::out_item_t out_item_q;
  tsr_pkg::out_item_t result;
  logic               out_adv;
  logic               step;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  tsr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (in_item_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[sv/tsr_core.sv]
module tsr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_data_i,
  input  logic                step_i,
  input  tsr_pkg::in_item_t   item_i,
  output tsr_pkg::out_item_t  result_o
);

  logic [11:0]                      max_frag_q;
  logic [tsr_pkg::FragWidth-1:0]    frag_bytes_q, frag_bytes_d;
  logic [tsr_pkg::SeqWidth-1:0]     exp_seq_q, exp_seq_d;
  logic [7:0]                       seg_left_q, seg_left_d;
  logic                             seg_acc_q, seg_acc_d;
  logic                             seg_fin_q, seg_fin_d;

  logic [tsr_pkg::SeqWidth-1:0]     hdr_seq;
  logic [7:0]                       payload_len;
  logic [tsr_pkg::LimitWidth-1:0]   limit;
  logic [tsr_pkg::LimitWidth-1:0]   frag_wide;
  logic [tsr_pkg::LimitWidth-1:0]   room;
  logic [tsr_pkg::FragWidth-1:0]    frag_inc;
  logic [7:0]                       left_dec;

  assign hdr_seq     = item_i.data_byte[tsr_pkg::SeqWidth-1:0];
  assign payload_len = item_i.segment_length - 8'd1;
  assign frag_inc    = frag_bytes_q + tsr_pkg::FragWidth'(1);
  assign left_dec    = seg_left_q - 8'd1;

  always_comb begin
    if ({1'b0, max_frag_q} < tsr_pkg::LimitWidth'(tsr_pkg::FragmentCapacity)) begin
      limit = {1'b0, max_frag_q};
    end else begin
      limit = tsr_pkg::LimitWidth'(tsr_pkg::FragmentCapacity);
    end
  end

  always_comb begin
    frag_bytes_d = frag_bytes_q;
    exp_seq_d    = exp_seq_q;
    seg_left_d   = seg_left_q;
    seg_acc_d    = seg_acc_q;
    seg_fin_d    = seg_fin_q;
    result_o     = '0;
    frag_wide    = '0;
    room         = '0;

    if (item_i.first_of_segment) begin
      seg_acc_d = 1'b0;
      seg_fin_d = 1'b0;
      if (item_i.segment_length < 8'(tsr_pkg::MinSegment)) begin
        seg_left_d = 8'd0;
        result_o.segment_status = tsr_pkg::StatusNoPayload;
      end else begin
        seg_left_d = payload_len;
        if (item_i.segment_length > 8'(tsr_pkg::MaxSegmentLength)) begin
          result_o.segment_status = tsr_pkg::StatusTooLong;
        end else if (!item_i.data_byte[tsr_pkg::FirBit] && frag_bytes_q == '0) begin
          result_o.segment_status = tsr_pkg::StatusNoFirst;
        end else begin
          if (item_i.data_byte[tsr_pkg::FirBit]) begin
            exp_seq_d = hdr_seq;
            if (frag_bytes_q != '0) begin
              result_o.fragment_abort = 1'b1;
            end
            frag_bytes_d = '0;
          end
          frag_wide = {1'b0, frag_bytes_d};
          room      = limit - frag_wide;
          if (hdr_seq != exp_seq_d) begin
            result_o.segment_status = tsr_pkg::StatusBadSeq;
          end else if (frag_wide > limit
                       || room < tsr_pkg::LimitWidth'(payload_len)) begin
            if (frag_bytes_d != '0) begin
              result_o.fragment_abort = 1'b1;
            end
            frag_bytes_d = '0;
            result_o.segment_status = tsr_pkg::StatusOverflow;
          end else begin
            exp_seq_d = exp_seq_d + tsr_pkg::SeqWidth'(1);
            seg_acc_d = 1'b1;
            seg_fin_d = item_i.data_byte[tsr_pkg::FinBit];
            result_o.segment_status = tsr_pkg::StatusHeaderOk;
          end
        end
      end
    end else if (!seg_acc_q || seg_left_q == 8'd0) begin
      if (seg_left_q != 8'd0) begin
        seg_left_d = left_dec;
      end
      result_o.segment_status = tsr_pkg::StatusDroppedByte;
    end else begin
      result_o.payload_valid  = 1'b1;
      result_o.payload_byte   = item_i.data_byte;
      result_o.payload_offset = frag_bytes_q[tsr_pkg::OffsetWidth-1:0];
      result_o.segment_status = tsr_pkg::StatusPayload;
      frag_bytes_d = frag_inc;
      seg_left_d   = left_dec;
      if (left_dec == 8'd0) begin
        seg_acc_d = 1'b0;
        seg_fin_d = 1'b0;
        if (seg_fin_q) begin
          result_o.fragment_done   = 1'b1;
          result_o.fragment_length = frag_inc;
          frag_bytes_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frag_q   <= tsr_pkg::MaxFragmentReset;
      frag_bytes_q <= '0;
      exp_seq_q    <= '0;
      seg_left_q   <= '0;
      seg_acc_q    <= 1'b0;
      seg_fin_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_frag_q <= cfg_data_i;
      end
      if (step_i) begin
        frag_bytes_q <= frag_bytes_d;
        exp_seq_q    <= exp_seq_d;
        seg_left_q   <= seg_left_d;
        seg_acc_q    <= seg_acc_d;
        seg_fin_q    <= seg_fin_d;
      end
    end
  end

endmodule
